@@ hw/rtl/cqd_pkg.sv @@
// shared types, constants and widths of the codel queue drop controller
`default_nettype none

package cqd_pkg;

  localparam int unsigned TIME_BITS  = 40;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned FIELD_TIME_W = 40;
  localparam int unsigned QLEN_W       = 16;
  localparam int unsigned TGT_W        = 24;
  localparam int unsigned IVAL_W       = 24;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam int unsigned NOW_LSB     = 0;
  localparam int unsigned QLEN_LSB    = NOW_LSB + FIELD_TIME_W;
  localparam int unsigned SOJ_LSB     = QLEN_LSB + QLEN_W;
  localparam int unsigned IN_FIELDS_W = SOJ_LSB + FIELD_TIME_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned SQ_W       = 2 * IVAL_W;
  localparam int unsigned RT_W       = IVAL_W;
  localparam int unsigned STEPS      = 2;
  localparam int unsigned DIV_ITERS  = SQ_W / STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);
  localparam int unsigned SQRT_ITERS = RT_W / STEPS;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_ITERS);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [QLEN_W-1:0] QUEUE_LIMIT_RST = QLEN_W'(100);
  localparam logic [TGT_W-1:0]  TARGET_RST      = TGT_W'(20000);
  localparam logic [IVAL_W-1:0] IVAL_RST        = IVAL_W'(100000);

  localparam logic [IN_TUSER_W-1:0] CMD_ARRIVAL = 2'd0;
  localparam logic [IN_TUSER_W-1:0] CMD_DEPART  = 2'd1;
  localparam logic [IN_TUSER_W-1:0] CMD_EMPTY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_INTERVAL = 2'd2;

  typedef enum logic [1:0] {
    OP_ARRIVAL,
    OP_DEPART,
    OP_EMPTY,
    OP_IGNORE
  } op_e;

  typedef enum logic [OUT_TUSER_W-1:0] {
    DROP_NONE  = 2'd0,
    DROP_TAIL  = 2'd1,
    DROP_CODEL = 2'd2
  } drop_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT
  } back_state_e;

  typedef struct packed {
    op_e                  op;
    logic                 over_limit;
    logic                 above_target;
    logic [TIME_BITS-1:0] now;
  } ev_t;

endpackage

`default_nettype wire

@@ hw/rtl/cqd_front.sv @@
// front end: config registers, request classification and event queue
`default_nettype none

module cqd_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cqd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cqd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [cqd_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  wire logic [cqd_pkg::IN_TUSER_W-1:0]    s_tuser_i,
  input  wire logic                              pop_i,
  output logic                                   head_valid_o,
  output cqd_pkg::ev_t                           head_o,
  output logic [cqd_pkg::IVAL_W-1:0]             ival_o
);
  import cqd_pkg::*;

  logic [QLEN_W-1:0] qlimit_q;
  logic [TGT_W-1:0]  target_q;
  logic [IVAL_W-1:0] ival_q;

  ev_t                  mem_q [FIFO_DEPTH];
  ev_t                  wr_ev;
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   fill_q, fill_d;
  logic                  push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlimit_q <= QUEUE_LIMIT_RST;
      target_q <= TARGET_RST;
      ival_q   <= IVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUEUE_LIMIT:      qlimit_q <= cfg_data_i[QLEN_W-1:0];
        REG_TARGET_DELAY:     target_q <= cfg_data_i[TGT_W-1:0];
        REG_OBSERVE_INTERVAL: ival_q   <= cfg_data_i[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // classify the request
  always_comb begin
    case (s_tuser_i)
      CMD_ARRIVAL: wr_ev.op = OP_ARRIVAL;
      CMD_DEPART:  wr_ev.op = OP_DEPART;
      CMD_EMPTY:   wr_ev.op = OP_EMPTY;
      default:     wr_ev.op = OP_IGNORE;
    endcase
    wr_ev.over_limit   = s_tdata_i[QLEN_LSB +: QLEN_W] >= qlimit_q;
    wr_ev.above_target = s_tdata_i[SOJ_LSB +: FIELD_TIME_W] >= FIELD_TIME_W'(target_q);
    wr_ev.now          = TIME_BITS'(s_tdata_i[NOW_LSB +: FIELD_TIME_W]);
  end

  assign s_tready_o   = fill_q != (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign push         = s_tvalid_i && s_tready_o;
  assign head_valid_o = fill_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign ival_o       = ival_q;

  always_comb begin
    fill_d = fill_q;
    if (push && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_ev;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cqd_div.sv @@
// iterative restoring divider, two quotient bits per cycle
`default_nettype none

module cqd_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [cqd_pkg::SQ_W-1:0]         dividend_i,
  input  wire logic [cqd_pkg::COUNT_BITS-1:0]   divisor_i,
  output logic                                  done_o,
  output logic [cqd_pkg::SQ_W-1:0]              quot_o
);
  import cqd_pkg::*;

  logic                  busy_q, done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [COUNT_BITS-1:0] dvs_q, rem_q, rem_d;
  logic [SQ_W-1:0]       quo_q, quo_d;

  always_comb begin
    logic [COUNT_BITS-1:0] r;
    logic [SQ_W-1:0]       q;
    logic [COUNT_BITS:0]   t;
    r = rem_q;
    q = quo_q;
    t = '0;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, q[SQ_W-1]};
      q = {q[SQ_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t    = t - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
      r = t[COUNT_BITS-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/cqd_sqrt.sv @@
// iterative integer square root, two root bits per cycle
`default_nettype none

module cqd_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cqd_pkg::SQ_W-1:0]  value_i,
  output logic                           done_o,
  output logic [cqd_pkg::RT_W-1:0]       root_o
);
  import cqd_pkg::*;

  logic                  busy_q, done_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]       val_q, val_d;
  logic [RT_W:0]         rem_q, rem_d;
  logic [RT_W-1:0]       root_q, root_d;

  always_comb begin
    logic [RT_W:0]   r;
    logic [RT_W-1:0] rt;
    logic [SQ_W-1:0] v;
    logic [RT_W+1:0] t;
    logic [RT_W+1:0] trial;
    r     = rem_q;
    rt    = root_q;
    v     = val_q;
    t     = '0;
    trial = '0;
    for (int k = 0; k < STEPS; k++) begin
      t     = {r[RT_W-1:0], v[SQ_W-1 -: 2]};
      v     = {v[SQ_W-3:0], 2'b00};
      trial = {rt, 2'b01};
      if (t >= trial) begin
        t  = t - trial;
        rt = {rt[RT_W-2:0], 1'b1};
      end else begin
        rt = {rt[RT_W-2:0], 1'b0};
      end
      r = t[RT_W:0];
    end
    rem_d  = r;
    root_d = rt;
    val_d  = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == SQRT_CNT_W'(SQRT_ITERS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQRT_CNT_W'(SQRT_ITERS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= val_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hw/rtl/cqd_back.sv @@
// back end: codel state, drop decisions, drop spacing and result register
`default_nettype none

module cqd_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              head_valid_i,
  input  wire cqd_pkg::ev_t                      head_i,
  output logic                                   pop_o,
  input  wire logic [cqd_pkg::IVAL_W-1:0]        ival_i,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [cqd_pkg::OUT_TDATA_W-1:0]        m_tdata_o,
  output logic [cqd_pkg::OUT_TUSER_W-1:0]        m_tuser_o
);
  import cqd_pkg::*;

  back_state_e st_q, st_d;

  logic                  dropping_q, dropping_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [TIME_BITS-1:0]  ndt_q, ndt_d;
  logic [TIME_BITS-1:0]  fat_q, fat_d;

  logic       out_valid_q, out_valid_d;
  logic       out_acc_q, out_acc_d;
  logic       out_drop_q, out_drop_d;
  drop_kind_e out_kind_q, out_kind_d;

  logic                 div_start, div_done, sqrt_start, sqrt_done;
  logic [SQ_W-1:0]      ival_sq, quot;
  logic [RT_W-1:0]      root;
  logic [TIME_BITS-1:0] ival_t;
  logic                 recent, long_above;

  assign ival_t     = TIME_BITS'(ival_i);
  assign ival_sq    = SQ_W'(ival_i) * SQ_W'(ival_i);
  assign recent     = (head_i.now < ndt_q) || ((head_i.now - ndt_q) < ival_t);
  assign long_above = (head_i.now - fat_q) >= ival_t;

  always_comb begin
    st_d        = st_q;
    dropping_d  = dropping_q;
    count_d     = count_q;
    ndt_d       = ndt_q;
    fat_d       = fat_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_acc_d   = out_acc_q;
    out_kind_d  = out_kind_q;
    out_drop_d  = out_drop_q;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (head_valid_i && (!out_valid_q || m_tready_i)) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_acc_d   = 1'b0;
          out_kind_d  = DROP_NONE;
          case (head_i.op)
            OP_ARRIVAL: begin
              if (head_i.over_limit) begin
                out_kind_d = DROP_TAIL;
              end else if (dropping_q && (head_i.now >= ndt_q)) begin
                if (count_q != '1) begin
                  count_d = count_q + 1'b1;
                end
                out_kind_d = DROP_CODEL;
                div_start  = 1'b1;
                st_d       = ST_DIV;
              end else begin
                out_acc_d = 1'b1;
              end
            end
            OP_DEPART: begin
              if (dropping_q && !head_i.above_target) begin
                dropping_d = 1'b0;
                fat_d      = '0;
              end else if (!dropping_q && head_i.above_target) begin
                if (fat_q == '0) begin
                  fat_d = head_i.now + ival_t;
                end else if ((head_i.now >= fat_q) && (recent || long_above)) begin
                  dropping_d = 1'b1;
                  ndt_d      = head_i.now;
                  if (recent && (count_q > COUNT_BITS'(2))) begin
                    count_d = count_q - COUNT_BITS'(2);
                  end else begin
                    count_d = '0;
                  end
                end
              end
            end
            OP_EMPTY: begin
              if (dropping_q) begin
                dropping_d = 1'b0;
                fat_d      = '0;
              end
            end
            default: ;
          endcase
          out_drop_d = dropping_d;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          st_d       = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          ndt_d = ndt_q + TIME_BITS'(root);
          st_d  = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dropping_q  <= 1'b0;
      count_q     <= '0;
      ndt_q       <= '0;
      fat_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dropping_q  <= dropping_d;
      count_q     <= count_d;
      ndt_q       <= ndt_d;
      fat_q       <= fat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q  <= out_acc_d;
    out_kind_q <= out_kind_d;
    out_drop_q <= out_drop_d;
  end

  cqd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ival_sq),
    .divisor_i  (count_d),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  cqd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_TDATA_W - 2)'(0), out_drop_q, out_acc_q};
  assign m_tuser_o  = out_kind_q;

endmodule

`default_nettype wire

@@ hw/rtl/codel_queue_drop_controller.sv @@
// top level of the codel queue drop controller
`default_nettype none

// CoDel drop controller for one packet queue: each request (arrival, departure
// or queue-empty) gives exactly one result with the admit flag, the drop kind
// and the dropping state after the request. Requests pass through a two-entry
// queue to the decision logic; a CoDel drop holds back the next request until
// the iterative divider (interval squared over drop count, two bits a cycle)
// and the iterative square root (two bits a cycle) have produced the next
// drop time. Config registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i: 0 queue limit, 1 target delay, 2 observe interval.

module codel_queue_drop_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cqd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cqd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // now_time, queue_length, queue_delay
  input  wire logic [cqd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  wire logic [cqd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // accepted, in_dropping, zero fill
  output logic [cqd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // drop_kind
  output logic [cqd_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);
  import cqd_pkg::*;

  logic              head_valid, pop;
  ev_t               head;
  logic [IVAL_W-1:0] ival;

  cqd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .ival_o       (ival)
  );

  cqd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .ival_i       (ival),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cqd_checker.sv @@
// port-level checks of the codel queue drop controller and their binding
`default_nettype none

module cqd_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [cqd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic [cqd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
  import cqd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an admitted arrival is never a drop
  a_acc_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == DROP_NONE)
    else $error("admitted request carries a drop kind");

  // codel drops only happen in the dropping state
  a_codel_dropping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == DROP_CODEL) |-> m_axis_tdata[1])
    else $error("codel drop outside dropping state");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:2] == '0)
    else $error("result padding not zero");

endmodule

bind codel_queue_drop_controller cqd_checker u_cqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_codel_queue_drop_controller.sv @@
`timescale 1ns / 100ps
// testbench for the codel queue drop controller: directed table, then random requests checked
module tb_codel_queue_drop_controller;
  import cqd_pkg::*;

  typedef struct packed {
    logic       acc;
    drop_kind_e kind;
    logic       drp;
  } verdict_t;

  typedef struct {
    op_e         op;
    logic [39:0] now;
    logic [15:0] qlen;
    logic [39:0] soj;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  localparam logic [39:0] T_MAX  = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] T_WRAP = 40'hFF_FFFE_7960;
  localparam verdict_t    V_NONE = '{1'b0, DROP_NONE, 1'b0};
  localparam verdict_t    V_PASS = '{1'b1, DROP_NONE, 1'b0};
  localparam verdict_t    V_TAIL = '{1'b0, DROP_TAIL, 1'b0};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // now_time, queue_length, queue_delay
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // command
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // accepted, in_dropping, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // drop_kind
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  logic [15:0] cfg_limit;
  logic [23:0] cfg_target;
  logic [23:0] cfg_ival;
  logic        pr_dropping;
  logic [15:0] pr_count;
  logic [39:0] pr_next_drop;
  logic [39:0] pr_first_above;

  verdict_t    pending_verdicts[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int unsigned src_idle = 20;
  int unsigned sink_idle = 72;

  plan_row_t plan [24] = '{
    '{OP_ARRIVAL, 40'd0,      16'd0,     40'd0,      1'b1, V_PASS},
    '{OP_ARRIVAL, 40'd10,     16'd100,   40'd0,      1'b1, V_TAIL},
    '{OP_ARRIVAL, 40'd20,     16'hFFFF,  T_MAX,      1'b1, V_TAIL},
    '{OP_ARRIVAL, 40'd30,     16'd99,    40'd0,      1'b1, V_PASS},
    '{OP_DEPART,  40'd40,     16'd0,     40'd0,      1'b1, V_NONE},
    '{OP_DEPART,  40'd1000,   16'd0,     40'd20000,  1'b1, V_NONE},
    '{OP_DEPART,  40'd50000,  16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_DEPART,  40'd101000, 16'd0,     T_MAX,      1'b0, V_NONE},
    '{OP_DEPART,  40'd201000, 16'd0,     40'd25000,  1'b0, V_NONE},
    '{OP_ARRIVAL, 40'd201000, 16'd5,     40'd0,      1'b0, V_NONE},
    '{OP_ARRIVAL, 40'd250000, 16'd5,     40'd0,      1'b0, V_NONE},
    '{OP_ARRIVAL, 40'd301000, 16'd5,     40'd0,      1'b0, V_NONE},
    '{OP_IGNORE,  T_MAX,      16'hFFFF,  T_MAX,      1'b0, V_NONE},
    '{OP_DEPART,  40'd301000, 16'd0,     40'd19999,  1'b0, V_NONE},
    '{OP_DEPART,  40'd301000, 16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_DEPART,  40'd350000, 16'd0,     40'd10,     1'b0, V_NONE},
    '{OP_DEPART,  40'd401000, 16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_ARRIVAL, 40'd401000, 16'd0,     40'd0,      1'b0, V_NONE},
    '{OP_DEPART,  40'd420000, 16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_EMPTY,   40'd430000, 16'd0,     40'd0,      1'b0, V_NONE},
    '{OP_EMPTY,   40'd440000, 16'd0,     40'd0,      1'b0, V_NONE},
    '{OP_DEPART,  T_WRAP,     16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_DEPART,  T_WRAP,     16'd0,     40'd30000,  1'b0, V_NONE},
    '{OP_ARRIVAL, T_MAX,      16'd0,     40'd0,      1'b1, V_PASS}
  };

  codel_queue_drop_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // interval / sqrt(count), via the integer root of interval^2 / count
  function automatic logic [39:0] drop_gap(input logic [23:0] ival, input logic [15:0] cnt);
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    if (cnt == 16'd0) return 40'(ival);
    sq = (64'(ival) * 64'(ival)) / 64'(cnt);
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root[39:0];
  endfunction

  task automatic codel_decide(input op_e op, input logic [39:0] now, input logic [15:0] qlen,
                              input logic [39:0] soj, output verdict_t v);
    logic recent;
    logic long_above;
    v = V_NONE;
    case (op)
      OP_ARRIVAL: begin
        if (qlen >= cfg_limit) begin
          v.kind = DROP_TAIL;
        end else if (pr_dropping && now >= pr_next_drop) begin
          if (pr_count != 16'hFFFF) pr_count = pr_count + 16'd1;
          pr_next_drop = pr_next_drop + drop_gap(cfg_ival, pr_count);
          v.kind = DROP_CODEL;
        end else begin
          v.acc = 1'b1;
        end
      end
      OP_DEPART: begin
        if (pr_dropping && soj < 40'(cfg_target)) begin
          pr_first_above = 40'd0;
          pr_dropping = 1'b0;
        end else if (!pr_dropping && soj >= 40'(cfg_target)) begin
          if (pr_first_above == 40'd0) begin
            pr_first_above = now + 40'(cfg_ival);
          end else if (now >= pr_first_above) begin
            recent = (now < pr_next_drop) || ((now - pr_next_drop) < 40'(cfg_ival));
            long_above = (now - pr_first_above) >= 40'(cfg_ival);
            if (recent || long_above) begin
              pr_dropping = 1'b1;
              if (recent) pr_count = (pr_count > 16'd2) ? pr_count - 16'd2 : 16'd0;
              else pr_count = 16'd0;
              pr_next_drop = now;
            end
          end
        end
      end
      OP_EMPTY: begin
        if (pr_dropping) begin
          pr_first_above = 40'd0;
          pr_dropping = 1'b0;
        end
      end
      default: ;
    endcase
    v.drp = pr_dropping;
  endtask

  task automatic send_request(input op_e op, input logic [39:0] now, input logic [15:0] qlen,
                              input logic [39:0] soj, output verdict_t v);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({soj, qlen, now});
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (requests_sent < 150) begin
      src_idle = 20;
      sink_idle = 72;
    end else if (requests_sent < 300) begin
      src_idle = 72;
      sink_idle = 20;
    end else begin
      src_idle = 0;
      sink_idle = 0;
    end
    codel_decide(op, now, qlen, soj, v);
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] lim, input logic [23:0] tgt,
                               input logic [23:0] ivl);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_QUEUE_LIMIT;
    cfg_data_i <= 24'(lim);
    @(negedge clk_i);
    cfg_idx_i  <= REG_TARGET_DELAY;
    cfg_data_i <= tgt;
    @(negedge clk_i);
    cfg_idx_i  <= REG_OBSERVE_INTERVAL;
    cfg_data_i <= ivl;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_limit  = lim;
    cfg_target = tgt;
    cfg_ival   = ivl;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.acc)
          report_mismatch($sformatf("accepted %b, expected %b", m_axis_tdata[0], want.acc));
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("drop_kind %0d, expected %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[1] !== want.drp)
          report_mismatch($sformatf("in_dropping %b, expected %b", m_axis_tdata[1], want.drp));
      end
    end
  end

  initial begin
    op_e         op;
    logic [39:0] now;
    logic [39:0] soj;
    logic [39:0] t_now;
    logic [15:0] qlen;
    logic [15:0] lim;
    logic [23:0] tgt;
    logic [23:0] ivl;
    verdict_t    v;
    int unsigned roll;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_QUEUE_LIMIT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ARRIVAL;
    cfg_limit      = QUEUE_LIMIT_RST;
    cfg_target     = TARGET_RST;
    cfg_ival       = IVAL_RST;
    pr_dropping    = 1'b0;
    pr_count       = 16'd0;
    pr_next_drop   = 40'd0;
    pr_first_above = 40'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      send_request(plan[k].op, plan[k].now, plan[k].qlen, plan[k].soj, v);
      pending_verdicts.push_back(plan[k].typed ? plan[k].want : v);
    end

    for (int p = 0; p < 6; p++) begin
      drain_requests();
      case (p)
        0: begin lim = 16'd0; tgt = 24'd0; ivl = 24'd1; end
        1: begin lim = 16'hFFFF; tgt = 24'hFF_FFFF; ivl = 24'hFF_FFFF; end
        2: begin
          lim = 16'($urandom_range(200, 1));
          tgt = 24'($urandom_range(5000, 100));
          ivl = 24'($urandom_range(50000, 1000));
        end
        3: begin lim = 16'd20; tgt = 24'd1000; ivl = 24'd0; end
        4: begin lim = 16'($urandom); tgt = 24'($urandom); ivl = 24'($urandom); end
        default: begin lim = QUEUE_LIMIT_RST; tgt = TARGET_RST; ivl = IVAL_RST; end
      endcase
      load_settings(lim, tgt, ivl);
      // odd phases start 25 observe intervals below the time wrap (at zero when the interval is zero)
      if (p % 2 == 1) t_now = 40'd0 - 40'(ivl) * 40'd25;
      else t_now = 40'({$urandom, $urandom});
      for (int k = 0; k < 75; k++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          op   = op_e'($urandom_range(3));
          now  = 40'({$urandom, $urandom});
          qlen = 16'($urandom);
          soj  = 40'({$urandom, $urandom});
        end else begin
          roll = $urandom_range(99);
          op = roll < 45 ? OP_ARRIVAL : roll < 85 ? OP_DEPART : roll < 95 ? OP_EMPTY : OP_IGNORE;
          t_now = t_now + 40'($urandom_range(cfg_ival / 4 + 2));
          now   = t_now;
          qlen  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(cfg_limit));
          soj   = ($urandom_range(9) == 0) ? 40'({$urandom, $urandom})
                                           : 40'($urandom_range(2 * cfg_target + 1));
        end
        send_request(op, now, qlen, soj, v);
        pending_verdicts.push_back(v);
      end
    end

    drain_requests();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ codel_queue_drop_controller.f @@
hw/rtl/cqd_pkg.sv
hw/rtl/cqd_front.sv
hw/rtl/cqd_div.sv
hw/rtl/cqd_sqrt.sv
hw/rtl/cqd_back.sv
hw/rtl/codel_queue_drop_controller.sv
hw/rtl/cqd_checker.sv
tb/tb_codel_queue_drop_controller.sv
